@@ hw/rtl/dcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// dcbd_pkg
// Types, constants and the depth offset table for the dense-code bit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dcbd_pkg;

  localparam int unsigned IndexBits = 25;
  // Products of a value with 7 or 9 plus small terms fit in four more bits.
  // The largest depth offset needs 22 bits, so narrow indexes still get those.
  localparam int unsigned ProdBits  = ((IndexBits > 22) ? IndexBits : 22) + 4;

  localparam logic [3:0] Stoppers    = 4'd7;
  localparam logic [3:0] MaxDepth    = 4'd7;
  localparam logic [1:0] LastBitPos  = 2'd3;
  localparam logic [IndexBits-1:0] DictSizeReset = IndexBits'(262144);

  typedef struct packed {
    logic code_bit;
    logic stream_last;
  } in_item_t;

  typedef struct packed {
    logic [IndexBits-1:0] word_index;
    logic                 space_after;
    logic                 has_word;
    logic                 stream_end;
    logic                 stopped;
  } out_item_t;

  typedef struct packed {
    logic [2:0]           digit_bits;
    logic [1:0]           bit_position;
    logic [IndexBits-1:0] running_value;
    logic                 value_overflow;
    logic [3:0]           extension_depth;
    logic                 pending_word;
    logic [IndexBits-1:0] pending_index;
    logic                 halted;
  } state_t;

  // Index of the first word at a given depth: sum over k < d of 7 * 9^k.
  function automatic logic [ProdBits-1:0] depth_base(input logic [2:0] depth);
    logic [ProdBits-1:0] base;
    case (depth)
      3'd0:    base = ProdBits'(0);
      3'd1:    base = ProdBits'(7);
      3'd2:    base = ProdBits'(70);
      3'd3:    base = ProdBits'(637);
      3'd4:    base = ProdBits'(5740);
      3'd5:    base = ProdBits'(51667);
      3'd6:    base = ProdBits'(465010);
      default: base = ProdBits'(4185097);
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dcbd_decode.sv @@
// ----------------------------------------------------------------------------
// dcbd_decode
// Next-state and result logic for one stream bit.
// ----------------------------------------------------------------------------
`default_nettype none

module dcbd_decode import dcbd_pkg::*; (
  input  wire in_item_t             item_i,
  input  wire state_t               state_i,
  input  wire logic [IndexBits-1:0] dict_size_i,
  output state_t                    state_o,
  output logic                      emit_o,
  output out_item_t                 result_o
);

  always_comb begin
    logic [3:0]          digit;
    logic [ProdBits-1:0] rv_ext;
    logic [ProdBits-1:0] dict_ext;
    logic [ProdBits-1:0] value;
    logic [ProdBits-1:0] idx;
    logic                bad;

    digit    = {state_i.digit_bits, item_i.code_bit};
    rv_ext   = ProdBits'(state_i.running_value);
    dict_ext = ProdBits'(dict_size_i);
    value    = (rv_ext << 3) + rv_ext + ProdBits'(digit - Stoppers);
    idx      = (rv_ext << 3) - rv_ext + ProdBits'(digit)
             + depth_base(state_i.extension_depth[2:0]);
    bad      = 1'b0;

    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '0;

    if (state_i.halted) begin
      if (item_i.stream_last) begin
        emit_o              = 1'b1;
        result_o.stream_end = 1'b1;
        result_o.stopped    = 1'b1;
      end
    end else if (state_i.pending_word) begin
      // This bit is the space flag of the word that just ended.
      emit_o               = 1'b1;
      result_o.word_index  = state_i.pending_index;
      result_o.space_after = item_i.code_bit;
      result_o.has_word    = 1'b1;
      result_o.stream_end  = item_i.stream_last;
      state_o.pending_word  = 1'b0;
      state_o.pending_index = '0;
    end else if (state_i.bit_position != LastBitPos) begin
      state_o.digit_bits   = {state_i.digit_bits[1:0], item_i.code_bit};
      state_o.bit_position = state_i.bit_position + 2'd1;
      if (item_i.stream_last) begin
        emit_o              = 1'b1;
        result_o.stream_end = 1'b1;
      end
    end else begin
      state_o.digit_bits   = '0;
      state_o.bit_position = '0;
      if (digit >= Stoppers) begin
        if (value >= dict_ext || value[ProdBits-1:IndexBits] != '0) begin
          state_o.value_overflow = 1'b1;
        end
        state_o.running_value = value[IndexBits-1:0];
        if (state_i.extension_depth <= MaxDepth) begin
          state_o.extension_depth = state_i.extension_depth + 4'd1;
        end
        if (item_i.stream_last) begin
          emit_o              = 1'b1;
          result_o.stream_end = 1'b1;
        end
      end else begin
        bad = state_i.value_overflow || (state_i.extension_depth > MaxDepth)
           || (idx >= dict_ext);
        state_o.running_value   = '0;
        state_o.value_overflow  = 1'b0;
        state_o.extension_depth = '0;
        if (bad) begin
          state_o.halted      = 1'b1;
          emit_o              = 1'b1;
          result_o.stream_end = item_i.stream_last;
          result_o.stopped    = 1'b1;
        end else if (item_i.stream_last) begin
          emit_o              = 1'b1;
          result_o.word_index = idx[IndexBits-1:0];
          result_o.has_word   = 1'b1;
          result_o.stream_end = 1'b1;
        end else begin
          state_o.pending_word  = 1'b1;
          state_o.pending_index = idx[IndexBits-1:0];
        end
      end
    end

    // The final bit of a stream returns everything to the start of a stream.
    if (item_i.stream_last) begin
      state_o = '0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dense_code_bit_decoder.sv @@
// ----------------------------------------------------------------------------
// dense_code_bit_decoder
// Serial decoder for a (7,9) dense code: one coded bit in, at most one
// dictionary index with its space flag out.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    in_item_t  (code bit, last)
//   out      output     out_valid_o / out_stall_i  out_item_t (index, flags)
//   cfg      input      cfg_we_i                   cfg_wdata_i (dictionary size)
//
// One bit is accepted every cycle while in_stall_o is low; its result, if any,
// passes the input register and then the result register before it is offered.
// The decode state is updated in the single pass between those registers.
// Reset clears the decode state and loads a dictionary size of 262144.
// A stalled output holds the result register; the input register then fills
// and stalls the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_code_bit_decoder import dcbd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [IndexBits-1:0] cfg_wdata_i
);

  logic                 in_valid_q, in_valid_d;
  in_item_t             in_q;
  state_t               state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q;
  logic [IndexBits-1:0] dict_size_q;
  logic                 emit;
  out_item_t            result;
  logic                 adv;
  logic                 load;

  // The held bit moves on when the result slot is empty or being taken.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign load       = in_valid_i && !in_stall_o;

  dcbd_decode u_decode (
    .item_i      (in_q),
    .state_i     (state_q),
    .dict_size_i (dict_size_q),
    .state_o     (state_d),
    .emit_o      (emit),
    .result_o    (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      dict_size_q <= DictSizeReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        dict_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_q <= in_item_i;
    end
    if (adv && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_word_not_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.has_word |-> !out_item_o.stopped)
    else $error("result carries a word and a stop flag");

  a_pending_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pending_word |-> state_q.bit_position == '0 && !state_q.halted)
    else $error("pending word while inside a digit or halted");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.stream_last |=> state_q == '0 && out_valid_o)
    else $error("final stream bit did not clear state or give a result");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(state_q))
    else $error("decode state moved while the result slot was blocked");
`endif

endmodule

`default_nettype wire
